// File: hw/rtl/int_to_decimal_ascii_macros.svh
// assertion macros used by the serialiser of the int_to_decimal_ascii design
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ITDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/itda_pkg.sv
// shared constants and types for the integer to decimal text converter
package itda_pkg;

  localparam int MagW          = 32;
  localparam int Digits        = 10;
  localparam int BcdW          = 4 * Digits;
  localparam int StepsPerStage = 8;
  localparam int DabStages     = MagW / StepsPerStage;
  localparam int RemW          = $clog2(Digits + 1);
  localparam int LzW           = $clog2(Digits);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  // payload between pipeline stages
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] bin;
    logic [BcdW-1:0] bcd;
  } dab_t;

endpackage

// File: hw/rtl/itda_in_if.sv
// input channel: one signed integer per transfer
interface itda_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: hw/rtl/itda_out_if.sv
// output channel: one ascii character per transfer
interface itda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       is_last;

  modport source (output valid, output ascii_char, output is_last, input ready);
  modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface

// File: hw/rtl/itda_front.sv
// entry stage: sign capture and unsigned magnitude
module itda_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output itda_pkg::dab_t      out_data
);

  logic           valid;
  itda_pkg::dab_t data;
  itda_pkg::dab_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // most negative value wraps to its own unsigned magnitude
  always_comb begin
    data_next.neg = in_value[31];
    data_next.bin = in_value[31] ? (itda_pkg::MagW)'(~in_value + 32'sd1)
                                 : (itda_pkg::MagW)'(in_value);
    data_next.bcd = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// File: hw/rtl/itda_dabble.sv
// one pipeline stage of shift-and-add-3 binary to bcd conversion
module itda_dabble (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  itda_pkg::dab_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output itda_pkg::dab_t out_data
);

  logic           valid;
  itda_pkg::dab_t data;
  itda_pkg::dab_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    logic [itda_pkg::BcdW-1:0] bcd;
    logic [itda_pkg::MagW-1:0] bin;
    bcd = in_data.bcd;
    bin = in_data.bin;
    for (int s = 0; s < itda_pkg::StepsPerStage; s++) begin
      for (int d = 0; d < itda_pkg::Digits; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      bcd = {bcd[itda_pkg::BcdW-2:0], bin[itda_pkg::MagW-1]};
      bin = {bin[itda_pkg::MagW-2:0], 1'b0};
    end
    data_next.neg = in_data.neg;
    data_next.bin = bin;
    data_next.bcd = bcd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

endmodule

// File: hw/rtl/itda_ser.sv
// character serialiser: sign, then significant digits, last one flagged
`include "int_to_decimal_ascii_macros.svh"

module itda_ser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  itda_pkg::dab_t in_data,
  itda_out_if.source     text
);

  logic                      busy;
  logic                      neg_pend;
  logic [itda_pkg::RemW-1:0] rem;
  logic [itda_pkg::BcdW-1:0] bcd;

  logic                      load;
  logic                      emit;
  logic                      last;
  logic [itda_pkg::LzW-1:0]  lz;

  assign last     = !neg_pend && (rem == itda_pkg::RemW'(1));
  assign emit     = busy && text.ready;
  assign in_ready = !busy || (text.ready && last);
  assign load     = in_valid && in_ready;

  assign text.valid      = busy;
  assign text.is_last    = last;
  assign text.ascii_char = neg_pend ? itda_pkg::CharMinus
                                    : (itda_pkg::CharZero | {4'd0, bcd[itda_pkg::BcdW-1 -: 4]});

  // leading zero digits, the units digit always kept
  always_comb begin
    lz = itda_pkg::LzW'(itda_pkg::Digits - 1);
    for (int d = 1; d < itda_pkg::Digits; d++) begin
      if (in_data.bcd[4*d +: 4] != 4'd0) begin
        lz = itda_pkg::LzW'(itda_pkg::Digits - 1 - d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (emit && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_pend <= in_data.neg;
      bcd      <= in_data.bcd << (4 * lz);
      rem      <= itda_pkg::RemW'(itda_pkg::Digits) - itda_pkg::RemW'(lz);
    end else if (emit) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        bcd <= {bcd[itda_pkg::BcdW-5:0], 4'd0};
        rem <= rem - itda_pkg::RemW'(1);
      end
    end
  end

  `ITDA_ASSERT_NOW(a_rem_range, busy,
    (rem != '0) && (rem <= itda_pkg::RemW'(itda_pkg::Digits)), "digit count out of range")
  `ITDA_ASSERT_NOW(a_digit_bcd, busy && !neg_pend,
    bcd[itda_pkg::BcdW-1 -: 4] <= 4'd9, "non-decimal digit presented")
  `ITDA_ASSERT_NEXT(a_drain, emit && last && !load,
    !busy, "serialiser still busy after last transfer")
  `ITDA_ASSERT_NEXT(a_advance, emit && !last && !load,
    busy && (!neg_pend || rem == $past(rem)), "serialiser did not advance")

endmodule

// File: hw/rtl/int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
// number: one signed two's complement integer per transfer (valid/ready).
// text:   one ASCII character per transfer, most significant first; a '-'
//         leads negative values, zero gives a single '0', no leading zeros,
//         and is_last marks the final character of each number.
// The first character of a number is presented from the serialiser register
// after the number has passed one entry stage and four bcd stages of eight
// shift steps each.
// Throughput: while text is ready, the serialiser puts out one character per
// cycle; a number has 1 to 11 characters, and the next number loads in the
// cycle the last character leaves, with no gap.
// New numbers keep entering the pipeline every cycle while earlier ones are
// serialised, until all stages are full.
// Reset clears every valid bit; nothing else is held between numbers.
// A stall on text holds the current character and backs up the pipeline
// stage by stage; nothing is lost or repeated.
module int_to_decimal_ascii (
  input  logic      clk,
  input  logic      rst,
  itda_in_if.sink   number,
  itda_out_if.source text
);

  localparam int N = itda_pkg::DabStages;

  logic           v   [N+1];
  logic           r   [N+1];
  itda_pkg::dab_t d   [N+1];

  itda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .in_value  (number.value),
    .out_valid (v[0]),
    .out_ready (r[0]),
    .out_data  (d[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_dab
    itda_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (r[i]),
      .in_data   (d[i]),
      .out_valid (v[i+1]),
      .out_ready (r[i+1]),
      .out_data  (d[i+1])
    );
  end

  itda_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v[N]),
    .in_ready (r[N]),
    .in_data  (d[N]),
    .text     (text)
  );

endmodule

// File: tb/itda_text_checker.sv
// checker for the integer to decimal text converter: predicts each number's text and compares
module itda_text_checker (
  input  logic clk,
  input  logic rst,
  itda_in_if   number,
  itda_out_if  text,
  output int   failures,
  output int   awaited,
  output int   numbers_taken,
  output int   chars_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       is_last;
  } text_char_t;

  text_char_t awaited_text[$];

  // decimal spelling of one number, most significant character first
  function automatic void spell_decimal(input logic [31:0] raw);
    logic [31:0] mag;
    logic [3:0]  digit_stack[$];
    text_char_t  c;
    // unsigned negate, so the most negative value gets its true magnitude
    mag = raw[31] ? 32'(-raw) : raw;
    do begin
      digit_stack.push_back(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (raw[31]) begin
      c.ascii_char = itda_pkg::CharMinus;
      c.is_last    = 1'b0;
      awaited_text.push_back(c);
    end
    while (digit_stack.size() > 0) begin
      c.ascii_char = itda_pkg::CharZero + 8'(digit_stack.pop_back());
      c.is_last    = (digit_stack.size() == 0);
      awaited_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      failures      = 0;
      numbers_taken = 0;
      chars_taken   = 0;
      awaited_text.delete();
    end else begin
      if (text.valid && text.ready) begin
        chars_taken++;
        if (awaited_text.size() == 0) begin
          failures++;
          $error("character transfer %h with no text pending", text.ascii_char);
        end else begin
          want = awaited_text.pop_front();
          if (text.ascii_char !== want.ascii_char) begin
            failures++;
            $error("ascii_char: expected %h, got %h", want.ascii_char, text.ascii_char);
          end
          if (text.is_last !== want.is_last) begin
            failures++;
            $error("is_last: expected %b, got %b", want.is_last, text.is_last);
          end
        end
      end
      if (number.valid && number.ready) begin
        numbers_taken++;
        spell_decimal(number.value);
      end
    end
    awaited = awaited_text.size();
  end

endmodule

// File: tb/int_to_decimal_ascii_test.sv
// testbench top for the integer to decimal text converter: stimulus, flow control and verdict
module int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit     = 4000;
  localparam int HoldCycles     = 300;
  localparam int IdlePercent    = 68;
  localparam int BothPercent    = 38;
  localparam int RandomPerPhase = 115;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itda_in_if  number ();
  itda_out_if text ();

  int failures;
  int awaited;
  int numbers_taken;
  int chars_taken;
  int idle_percent  = 0;
  int stall_percent = 0;
  int hold_requests = 0;
  int quiet_cycles  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int_to_decimal_ascii uut (
    .clk    (clk),
    .rst    (rst),
    .number (number),
    .text   (text)
  );

  itda_text_checker watch (
    .clk           (clk),
    .rst           (rst),
    .number        (number),
    .text          (text),
    .failures      (failures),
    .awaited       (awaited),
    .numbers_taken (numbers_taken),
    .chars_taken   (chars_taken)
  );

  // no transfer in either direction for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (number.valid && number.ready) || (text.valid && text.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold whenever one is requested
  initial begin
    int hold_left;
    int holds_served;
    text.ready   = 1'b0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        text.ready <= 1'b0;
      end else begin
        text.ready <= ($urandom_range(99) >= stall_percent);
      end
    end
  end

  task automatic offer_number(input logic [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < idle_percent) begin
      number.valid <= 1'b0;
      @(negedge clk);
    end
    number.valid <= 1'b1;
    number.value <= v;
    do @(posedge clk); while (!number.ready);
  endtask

  // stop offering until every predicted character has come out
  task automatic drain_text();
    @(negedge clk);
    number.valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  // mostly numbers of a chosen digit count and sign, some raw 32-bit patterns
  function automatic logic [31:0] random_number();
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] mag;
    logic        neg;
    if ($urandom_range(3) == 0) return $urandom;
    neg  = 1'($urandom_range(1));
    ndig = $urandom_range(1, 10);
    lo   = 1;
    repeat (ndig - 1) lo = lo * 10;
    if (ndig == 10) hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else hi = lo * 10 - 1;
    if (ndig == 1) lo = neg ? 1 : 0;
    mag = $urandom_range(hi, lo);
    return neg ? -mag : mag;
  endfunction

  initial begin
    logic [31:0] corners[$];
    number.valid = 1'b0;
    number.value = '0;
    corners = '{32'd0, 32'd1, -32'sd1, 32'd5, -32'sd7, 32'd9, 32'd10, -32'sd10,
                32'd99, 32'd100, -32'sd999, 32'd999999999, 32'd1000000000,
                -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, -32'sd987654321,
                32'hFFFF_FFFA};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corners[i]) offer_number(corners[i]);
    drain_text();

    // free running, idle sender, stalled receiver, then both
    for (int phase = 0; phase < 4; phase++) begin
      idle_percent  = (phase == 1) ? IdlePercent : (phase == 3) ? BothPercent : 0;
      stall_percent = (phase == 2) ? IdlePercent : (phase == 3) ? BothPercent : 0;
      // long output hold while numbers keep coming, so the pipeline backs up
      if (phase == 0) hold_requests++;
      for (int i = 0; i < RandomPerPhase; i++) offer_number(random_number());
      drain_text();
    end

    // margin past the pipeline depth for any stray character
    repeat (20) @(posedge clk);
    $display("converted %0d numbers into %0d characters: corners, all digit counts, both signs",
             numbers_taken, chars_taken);
    $display("flow control: free running, idle sender, stalled receiver, both, one %0d-cycle hold",
             HoldCycles);
    if (failures == 0 && awaited == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
